/* hw/rtl/lshahc_pkg.sv */
// Package: constants, widths and state type for the LSH amplified hash combiner.
package lshahc_pkg;

    // Prime modulus for the object id; 2^32 mod PRIME is 5.
    localparam logic [32:0] PRIME      = 33'd4294967291;
    localparam int          FOLD_CONST = 5;

    localparam int H_W      = 32;
    localparam int WEIGHT_W = 14;
    localparam int BCNT_W   = 25;
    localparam int BIDX_W   = 24;
    localparam int POS_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int CNT_W    = 5;

    localparam int NUM_WEIGHTS = 4;
    localparam int MUL_STEPS   = WEIGHT_W;
    localparam int DIV_STEPS   = H_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } lshahc_state_t;

endpackage

/* hw/rtl/lsh_amplified_hash_combiner.sv */
// Top level: serial weighted sum modulo a prime with bucket index by serial division.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid, s_ready, s_h_value             | in
//  result   | m_valid, m_ready, m_point_id,           | out
//           | m_bucket_index                          |
//  config   | cfg_we, cfg_index, cfg_data             | in
//
// Steps: an item that does not close a point passes through accept, 14 steps of the
// bit-serial weight multiplier, one fold of 2^32 into 5 and one modular add. The item that
// closes a point adds 32 steps of the restoring divider for the bucket index and a load
// of the output register.
// Reset: aresetn is synchronous, active low; clears the residue, position, weights (to 1)
// and bucket count (to 1). No clearing pass.
// Stalls: the result sits in an output register; the next point's items are taken
// while it waits. A finished point waits in ST_OUT only if the register is still full.
module lsh_amplified_hash_combiner #(
    parameter int NUM_TERMS = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [lshahc_pkg::H_W-1:0]     s_h_value,
    // result request channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lshahc_pkg::H_W-1:0]            m_point_id,
    output logic [lshahc_pkg::BIDX_W-1:0]         m_bucket_index,
    // configuration write port
    input  logic                                  cfg_we,
    input  logic [lshahc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lshahc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int H_W = lshahc_pkg::H_W;
    localparam int W_W = lshahc_pkg::WEIGHT_W;
    localparam int B_W = lshahc_pkg::BCNT_W;
    localparam int P_W = lshahc_pkg::POS_W;
    localparam int C_W = lshahc_pkg::CNT_W;
    localparam logic [P_W-1:0] LAST_POS = P_W'(NUM_TERMS - 1);

    // ---------------------------------------------------------------- config
    logic [W_W-1:0] weight_reg [lshahc_pkg::NUM_WEIGHTS];
    logic [B_W-1:0] bucket_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lshahc_pkg::NUM_WEIGHTS; i++) begin
                weight_reg[i] <= W_W'(1);
            end
            bucket_count_reg <= B_W'(1);
        end else if (cfg_we) begin
            if (cfg_index <= lshahc_pkg::REG_WEIGHT_3) begin
                weight_reg[cfg_index[1:0]] <= cfg_data[W_W-1:0];
            end else if (cfg_index == lshahc_pkg::REG_BUCKET_COUNT) begin
                bucket_count_reg <= cfg_data[B_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- state
    lshahc_pkg::lshahc_state_t state_reg, state_next;

    logic [C_W-1:0] cnt_reg;
    logic [P_W-1:0] term_pos_reg;
    logic [H_W-1:0] residue_reg;
    logic [H_W-1:0] h_reg;          // h reduced into [0, P)
    logic [W_W-1:0] w_sh_reg;       // weight, shifted out LSB first
    logic [H_W-1:0] acc_hi_reg;     // upper product bits
    logic [W_W-1:0] lo_reg;         // lower product bits, shifted in from the top
    logic [H_W-1:0] term_reg;
    logic [H_W-1:0] id_reg;
    logic [H_W-1:0] div_sh_reg;     // dividend, MSB first
    logic [B_W-1:0] rem_reg;
    logic           m_valid_reg;
    logic [H_W-1:0] m_point_id_reg;
    logic [lshahc_pkg::BIDX_W-1:0] m_bucket_index_reg;

    logic s_fire;
    logic out_free;
    logic is_last;
    logic mul_done;
    logic div_done;

    assign is_last  = (term_pos_reg == LAST_POS);
    assign mul_done = (cnt_reg == C_W'(lshahc_pkg::MUL_STEPS - 1));
    assign div_done = (cnt_reg == C_W'(lshahc_pkg::DIV_STEPS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lshahc_pkg::ST_IDLE: if (s_valid)  state_next = lshahc_pkg::ST_MUL;
            lshahc_pkg::ST_MUL:  if (mul_done) state_next = lshahc_pkg::ST_RED;
            lshahc_pkg::ST_RED:  state_next = lshahc_pkg::ST_ACC;
            lshahc_pkg::ST_ACC: begin
                state_next = is_last ? lshahc_pkg::ST_DIV : lshahc_pkg::ST_IDLE;
            end
            lshahc_pkg::ST_DIV:  if (div_done) state_next = lshahc_pkg::ST_OUT;
            lshahc_pkg::ST_OUT:  if (out_free) state_next = lshahc_pkg::ST_IDLE;
            default:             state_next = lshahc_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        s_ready  = (state_reg == lshahc_pkg::ST_IDLE);
        out_free = !m_valid_reg || m_ready;
    end

    assign s_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lshahc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- datapath
    logic [W_W-1:0] w_sel;
    logic [H_W:0]   mul_sum;
    logic [W_W-1:0] prod_hi;
    logic [H_W:0]   fold_sum;
    logic [H_W:0]   acc_sum;
    logic [H_W-1:0] term_mod;
    logic [H_W-1:0] acc_mod;
    logic [B_W:0]   div_trial;
    logic [B_W:0]   div_sub;

    always_comb begin
        if (term_pos_reg < P_W'(lshahc_pkg::NUM_WEIGHTS)) begin
            w_sel = weight_reg[term_pos_reg[1:0]];
        end else begin
            w_sel = W_W'(1);
        end
        // shift-add multiply step
        mul_sum  = {1'b0, acc_hi_reg} + (w_sh_reg[0] ? {1'b0, h_reg} : '0);
        // product = hi*2^32 + lo, and 2^32 = 5 mod P
        prod_hi  = acc_hi_reg[H_W-1:H_W-W_W];
        fold_sum = {1'b0, acc_hi_reg[H_W-W_W-1:0], lo_reg}
                 + (H_W+1)'({prod_hi, 2'b00}) + (H_W+1)'(prod_hi);
        term_mod = (fold_sum >= lshahc_pkg::PRIME) ? H_W'(fold_sum - lshahc_pkg::PRIME)
                                                   : fold_sum[H_W-1:0];
        acc_sum  = {1'b0, residue_reg} + {1'b0, term_reg};
        acc_mod  = (acc_sum >= lshahc_pkg::PRIME) ? H_W'(acc_sum - lshahc_pkg::PRIME)
                                                  : acc_sum[H_W-1:0];
        // restoring division step
        div_trial = {rem_reg, div_sh_reg[H_W-1]};
        div_sub   = div_trial - {1'b0, bucket_count_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_pos_reg <= '0;
            residue_reg  <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // a new result may replace one taken at this same edge
            if ((state_reg == lshahc_pkg::ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                lshahc_pkg::ST_IDLE: begin
                    if (s_fire) begin
                        // negative h: (h + 2^32) - 5 lands in [0, P)
                        h_reg      <= s_h_value[H_W-1]
                                    ? H_W'(s_h_value) - H_W'(lshahc_pkg::FOLD_CONST)
                                    : H_W'(s_h_value);
                        w_sh_reg   <= w_sel;
                        acc_hi_reg <= '0;
                        lo_reg     <= '0;
                        cnt_reg    <= '0;
                    end
                end
                lshahc_pkg::ST_MUL: begin
                    acc_hi_reg <= mul_sum[H_W:1];
                    lo_reg     <= {mul_sum[0], lo_reg[W_W-1:1]};
                    w_sh_reg   <= w_sh_reg >> 1;
                    cnt_reg    <= cnt_reg + C_W'(1);
                end
                lshahc_pkg::ST_RED: begin
                    term_reg <= term_mod;
                end
                lshahc_pkg::ST_ACC: begin
                    if (is_last) begin
                        id_reg       <= acc_mod;
                        div_sh_reg   <= acc_mod;
                        rem_reg      <= '0;
                        cnt_reg      <= '0;
                        residue_reg  <= '0;
                        term_pos_reg <= '0;
                    end else begin
                        residue_reg  <= acc_mod;
                        term_pos_reg <= term_pos_reg + P_W'(1);
                    end
                end
                lshahc_pkg::ST_DIV: begin
                    rem_reg    <= div_sub[B_W] ? div_trial[B_W-1:0] : div_sub[B_W-1:0];
                    div_sh_reg <= div_sh_reg << 1;
                    cnt_reg    <= cnt_reg + C_W'(1);
                end
                lshahc_pkg::ST_OUT: begin
                    if (out_free) begin
                        m_point_id_reg     <= id_reg;
                        // zero bucket count gives index zero
                        m_bucket_index_reg <= (bucket_count_reg == '0) ? '0
                                            : rem_reg[lshahc_pkg::BIDX_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_point_id     = m_point_id_reg;
    assign m_bucket_index = m_bucket_index_reg;

endmodule

/* test/tb_lsh_amplified_hash_combiner.sv */
// Testbench for lsh_amplified_hash_combiner: weighted hash sum mod prime and bucket index.
module tb_lsh_amplified_hash_combiner;

    localparam int H_W         = lshahc_pkg::H_W;
    localparam int BIDX_W      = lshahc_pkg::BIDX_W;
    localparam int WEIGHT_W    = lshahc_pkg::WEIGHT_W;
    localparam int BCNT_W      = lshahc_pkg::BCNT_W;
    localparam int POS_W       = lshahc_pkg::POS_W;
    localparam int CFG_IDX_W   = lshahc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = lshahc_pkg::CFG_DATA_W;
    localparam int NUM_WEIGHTS = lshahc_pkg::NUM_WEIGHTS;

    localparam int NUM_TERMS = 4;
    // Longest item is the one that closes a point. Leave some margin.
    localparam int DRAIN_CYCLES = 64;
    // Cycles without any accepted request before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_GAP = 8;
    localparam int REPORT_LIMIT = 10;

    // First index past the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = lshahc_pkg::REG_BUCKET_COUNT + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST = '1;

    localparam logic [H_W-1:0] H_MOST_NEG = 32'h8000_0000;
    localparam logic [H_W-1:0] H_MOST_POS = 32'h7FFF_FFFF;
    localparam logic [H_W-1:0] H_MINUS_ONE = 32'hFFFF_FFFF;

    localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = 14'd10000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ALL_ONES = '1;
    localparam logic [BCNT_W-1:0] BUCKETS_2_24 = 25'h100_0000;
    localparam logic [BCNT_W-1:0] BUCKETS_ALL_ONES = '1;

    typedef struct packed {
        logic [H_W-1:0]    point_id;
        logic [BIDX_W-1:0] bucket_index;
    } bucket_hit_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [H_W-1:0] s_h_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [H_W-1:0]        m_point_id;
    logic [BIDX_W-1:0]     m_bucket_index;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow of the block: registers and the partial sum of the point in flight.
    logic [WEIGHT_W-1:0] model_weight [NUM_WEIGHTS];
    logic [BCNT_W-1:0]   model_buckets;
    logic [H_W-1:0]      model_residue;
    logic [POS_W-1:0]    model_pos;

    // One entry per finished point, oldest first.
    bucket_hit_t pending_hits[$];

    int  mismatches = 0;
    int  hashes_sent = 0;
    int  points_closed = 0;
    int  configs_loaded = 0;
    int  quiet_cycles = 0;
    // When set, both sides run back to back with no gaps.
    bit  no_idle = 0;

    lsh_amplified_hash_combiner #(
        .NUM_TERMS(NUM_TERMS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_h_value     (s_h_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_point_id    (m_point_id),
        .m_bucket_index(m_bucket_index),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Fold one accepted hash value into the shadow sum; on the last term of a
    // point, queue the point id and bucket index the block must produce.
    task automatic accumulate_hash(input logic [H_W-1:0] h);
        bit [63:0]   mod_p;
        bit [63:0]   hv;
        bit [63:0]   w;
        bit [63:0]   term;
        bit [63:0]   sum;
        logic [31:0] rem;
        bucket_hit_t hit;
        mod_p = {31'b0, lshahc_pkg::PRIME};
        // Negative values are h + 2^32 as raw bits; move them to h + P.
        hv = h[H_W-1] ? ({32'b0, h} + mod_p - 64'h1_0000_0000) : {32'b0, h};
        // Positions past the weight registers count with a weight of one.
        w = (model_pos < NUM_WEIGHTS) ? {50'b0, model_weight[model_pos]} : 64'd1;
        term = (w * hv) % mod_p;
        sum = ({32'b0, model_residue} + term) % mod_p;
        model_residue = sum[31:0];
        if (model_pos + 1 >= NUM_TERMS) begin
            hit.point_id = model_residue;
            // A bucket count of zero gives index zero; the remainder is cut to 24 bits.
            rem = (model_buckets == '0) ? 32'd0 : model_residue % {7'b0, model_buckets};
            hit.bucket_index = rem[BIDX_W-1:0];
            pending_hits.push_back(hit);
            model_residue = '0;
            model_pos = '0;
            points_closed++;
        end else begin
            model_pos = model_pos + 1'b1;
        end
    endtask

    // Send one hash value. Called at a falling edge, returns at a falling edge
    // with s_valid still high so a zero gap keeps the request line up.
    task automatic send_hash(input logic [H_W-1:0] h);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_h_value <= h;
        do @(posedge aclk); while (!s_ready);
        accumulate_hash(h);
        hashes_sent++;
        @(negedge aclk);
    endtask

    // Hold off new requests until every point has come out, then give the block
    // time to finish any term that closes no point.
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_hits.size() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Program all five registers back to back, optionally followed by a write
    // to an index past the list that the block has to ignore.
    task automatic load_config(input logic [WEIGHT_W-1:0] w0, input logic [WEIGHT_W-1:0] w1,
                               input logic [WEIGHT_W-1:0] w2, input logic [WEIGHT_W-1:0] w3,
                               input logic [BCNT_W-1:0] buckets, input bit with_spare);
        logic [WEIGHT_W-1:0]          w [NUM_WEIGHTS];
        logic [CFG_DATA_W-WEIGHT_W-1:0] upper;
        quiesce();
        w[0] = w0;
        w[1] = w1;
        w[2] = w2;
        w[3] = w3;
        for (int i = 0; i < NUM_WEIGHTS; i++) begin
            // Bits above the weight width carry junk; only the low 14 count.
            upper = (CFG_DATA_W-WEIGHT_W)'($urandom);
            cfg_we <= 1'b1;
            cfg_index <= lshahc_pkg::REG_WEIGHT_0 + CFG_IDX_W'(i);
            cfg_data <= {upper, w[i]};
            model_weight[i] = w[i];
            @(negedge aclk);
        end
        cfg_index <= lshahc_pkg::REG_BUCKET_COUNT;
        cfg_data <= buckets;
        model_buckets = buckets;
        @(negedge aclk);
        if (with_spare) begin
            cfg_index <= CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
            cfg_data <= CFG_DATA_W'($urandom);
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        configs_loaded++;
        @(negedge aclk);
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 14'd1;
            2: return WEIGHT_TOP;
            3: return WEIGHT_ALL_ONES;
            default: return WEIGHT_W'($urandom_range(1, WEIGHT_TOP));
        endcase
    endfunction

    function automatic logic [BCNT_W-1:0] pick_buckets();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 25'd1;
            2: return BUCKETS_2_24;
            3: return BUCKETS_ALL_ONES;
            4: return BCNT_W'($urandom_range(1, 64));
            5: return BCNT_W'($urandom_range(1, BUCKETS_2_24));
            default: return BCNT_W'($urandom);
        endcase
    endfunction

    function automatic logic [H_W-1:0] pick_hash();
        case ($urandom_range(0, 9))
            0: return H_MOST_NEG;
            1: return H_MOST_POS;
            2: return H_MINUS_ONE;
            3: return '0;
            4: return H_W'($urandom_range(0, 31) - 16);
            default: return H_W'($urandom);
        endcase
    endfunction

    // Reset values: unit weights and a single bucket, so the id is the plain sum.
    task automatic test_reset_values();
        send_hash(32'd1);
        send_hash(32'd2);
        send_hash(32'd3);
        send_hash(32'd4);
    endtask

    // Largest weights against the signed extremes of the hash value.
    task automatic test_hash_extremes();
        load_config(WEIGHT_ALL_ONES, WEIGHT_ALL_ONES, WEIGHT_ALL_ONES, WEIGHT_ALL_ONES,
                    25'd1000, 1'b0);
        send_hash(H_MOST_POS);
        send_hash(H_MOST_NEG);
        send_hash(H_MINUS_ONE);
        send_hash('0);
        send_hash('0);
        send_hash('0);
        send_hash('0);
        send_hash('0);
    endtask

    // Zero weights, top and wrapped point id, and the bucket count corners:
    // zero, exactly 2^24, and the full 25-bit value.
    task automatic test_residue_corners();
        // Only -1 counts: id is P-1, bucket count zero gives index zero.
        load_config(14'd1, '0, '0, '0, '0, 1'b0);
        send_hash(H_MINUS_ONE);
        send_hash($urandom);
        send_hash($urandom);
        send_hash($urandom);
        // -1 + 1 wraps to an id of zero.
        load_config(14'd1, 14'd1, '0, '0, BUCKETS_ALL_ONES, 1'b0);
        send_hash(H_MINUS_ONE);
        send_hash(32'd1);
        send_hash($urandom);
        send_hash($urandom);
        load_config(14'd1, '0, '0, '0, BUCKETS_2_24, 1'b0);
        send_hash(H_MINUS_ONE);
        send_hash(H_MOST_NEG);
        send_hash(H_MOST_POS);
        send_hash(H_MINUS_ONE);
    endtask

    // A write to an index past the register list must leave every register alone.
    task automatic test_spare_index();
        load_config(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                    BCNT_W'($urandom_range(2, 64)), 1'b1);
        send_hash($urandom);
        send_hash($urandom);
        send_hash($urandom);
        send_hash($urandom);
    endtask

    // Random points under a series of register settings. Some phases end in
    // the middle of a point so the partial sum crosses a register update.
    task automatic test_random_points();
        int count;
        for (int phase = 0; phase < 12; phase++) begin
            load_config(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                        pick_buckets(), $urandom_range(0, 1));
            no_idle = (phase % 4 == 3);
            count = 96 + $urandom_range(0, 8);
            repeat (count) send_hash(pick_hash());
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stall before each result, none in the no-idle phases.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // Compare each accepted result with the oldest finished point.
    always @(posedge aclk) begin
        bucket_hit_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: point_id %h bucket_index %h",
                             m_point_id, m_bucket_index);
            end else begin
                want = pending_hits.pop_front();
                if (m_point_id !== want.point_id || m_bucket_index !== want.bucket_index) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: point_id exp %h got %h, bucket_index exp %h got %h",
                                 want.point_id, m_point_id, want.bucket_index,
                                 m_bucket_index);
                end
            end
        end
    end

    // Hang detection: any accepted request on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d idle cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_h_value = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < NUM_WEIGHTS; i++) model_weight[i] = 14'd1;
        model_buckets = 25'd1;
        model_residue = '0;
        model_pos = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_hash_extremes();
        test_residue_corners();
        test_spare_index();
        test_random_points();
        quiesce();

        $display("run covered %0d hash values in %0d points under %0d register settings",
                 hashes_sent, points_closed, configs_loaded);
        $display("mismatched results: %0d", mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
